// ----- rtl/core/image_psnr_meter_unit_assert.svh -----
// Assertion macros for the checker file of the PSNR meter.
`ifndef IMAGE_PSNR_METER_UNIT_ASSERT_SVH
`define IMAGE_PSNR_METER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IPM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IPM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/core/ipm_pkg.sv -----
// Shared types and constants of the PSNR meter.
package ipm_pkg;

   localparam int MANT_W     = 31;
   localparam int FRAC_STEPS = 16;
   localparam int DSUM_W     = 32;
   localparam int DEPTH_W    = 4;
   localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;
   localparam logic [15:0] PSNR_IDENT  = 16'hFF00;

   typedef enum logic [1:0] {
      LOG_SEL_PEAK  = 2'd0,
      LOG_SEL_SUM   = 2'd1,
      LOG_SEL_COUNT = 2'd2
   } log_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_LOG_LOAD,
      S_LOG_NORM,
      S_LOG_MUL,
      S_LOG_SEL,
      S_LOG_ACC,
      S_SCALE_MUL,
      S_SCALE_FIN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        acc_en;
      logic        div_start;
      logic        div_step;
      logic        log_load;
      log_sel_type log_sel;
      logic        norm_step;
      logic        log_mant;
      logic        sq_mul;
      logic        sq_sel;
      logic        dsum_add;
      logic        scale_mul;
      logic        scale_fin;
      logic        result_load;
      logic        clear;
   } cmd_type;

   typedef struct packed {
      logic sum_zero;
      logic log_top;
      logic rsp_busy;
   } status_type;

endpackage

// ----- rtl/core/ipm_controller.sv -----
// Sequencer of the PSNR meter: accumulate, divide, three logs, scale, deliver.
module ipm_controller import ipm_pkg::*; #(
   parameter int DIV_W = 46
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int CW = $clog2(DIV_W + 1);

   state_type   state_ff, state_in;
   logic [CW-1:0] step_ff, step_in;
   log_sel_type sel_ff, sel_in;
   logic        accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         sel_ff   <= LOG_SEL_PEAK;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sel_ff   <= sel_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      sel_in   = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_tlast) state_in = S_CHECK;
         end
         S_CHECK: begin
            step_in = '0;
            sel_in  = LOG_SEL_PEAK;
            state_in = status.sum_zero ? S_OUT : S_DIV;
         end
         S_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == CW'(DIV_W - 1)) state_in = S_LOG_LOAD;
         end
         S_LOG_LOAD: state_in = S_LOG_NORM;
         S_LOG_NORM: begin
            step_in = '0;
            if (status.log_top) state_in = S_LOG_MUL;
         end
         S_LOG_MUL: state_in = S_LOG_SEL;
         S_LOG_SEL: begin
            step_in = step_ff + 1'b1;
            state_in = (step_ff == CW'(FRAC_STEPS - 1)) ? S_LOG_ACC : S_LOG_MUL;
         end
         S_LOG_ACC: begin
            case (sel_ff)
               LOG_SEL_PEAK:  sel_in = LOG_SEL_SUM;
               LOG_SEL_SUM:   sel_in = LOG_SEL_COUNT;
               default:       sel_in = LOG_SEL_PEAK;
            endcase
            state_in = (sel_ff == LOG_SEL_COUNT) ? S_SCALE_MUL : S_LOG_LOAD;
         end
         S_SCALE_MUL: state_in = S_SCALE_FIN;
         S_SCALE_FIN: state_in = S_OUT;
         S_OUT: begin
            if (!status.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.log_sel = sel_ff;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.acc_en = accept;
         end
         S_CHECK:     cmd.div_start = !status.sum_zero;
         S_DIV:       cmd.div_step  = 1'b1;
         S_LOG_LOAD:  cmd.log_load  = 1'b1;
         S_LOG_NORM: begin
            cmd.norm_step = !status.log_top;
            cmd.log_mant  = status.log_top;
         end
         S_LOG_MUL:   cmd.sq_mul    = 1'b1;
         S_LOG_SEL:   cmd.sq_sel    = 1'b1;
         S_LOG_ACC:   cmd.dsum_add  = 1'b1;
         S_SCALE_MUL: cmd.scale_mul = 1'b1;
         S_SCALE_FIN: cmd.scale_fin = 1'b1;
         S_OUT: begin
            cmd.result_load = !status.rsp_busy;
            cmd.clear       = !status.rsp_busy;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- rtl/core/ipm_datapath.sv -----
// Datapath of the PSNR meter: accumulators, divider, log unit, scaler, output register.
module ipm_datapath import ipm_pkg::*; #(
   parameter int MAX_PIXELS = 1048576,
   parameter int CNT_W      = 21,
   parameter int SUM_W      = 37,
   parameter int DIV_W      = 46
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [7:0]         pixel_a,
   input  logic [7:0]         pixel_b,
   input  logic               csr_we,
   input  logic [DEPTH_W-1:0] csr_wdata,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [23:0]        rsp_mse,
   output logic [15:0]        rsp_psnr,
   output logic               rsp_identical
);

   localparam int LOG_W = (SUM_W < 32) ? 32 : SUM_W;
   localparam int E_W   = $clog2(LOG_W);

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [7:0]         diff;
   logic [15:0]        sq;

   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [CNT_W:0]     trial;

   logic [LOG_W-1:0]   logx_ff, logx_in;
   logic [E_W-1:0]     e_ff, e_in;
   logic [MANT_W-1:0]  y_ff, y_in;
   logic [61:0]        prod_ff, prod_in;
   logic [15:0]        frac_ff, frac_in;
   logic [31:0]        sq_top;
   logic [3:0]         depth_eff;
   logic [7:0]         peak;
   logic [LOG_W-1:0]   log_src;

   logic signed [DSUM_W-1:0] dsum_ff, dsum_in;
   logic [DSUM_W-1:0]  term;
   logic [DSUM_W-1:0]  mag;
   logic               neg_ff, neg_in;
   logic [62:0]        sprod_ff, sprod_in;
   logic [63:0]        rounded;
   logic [23:0]        q;
   logic [15:0]        psnr_ff, psnr_in;

   logic               vld_ff, vld_in;
   logic [23:0]        mse_ff, mse_in;
   logic [15:0]        out_psnr_ff, out_psnr_in;
   logic               ident_ff, ident_in;

   assign diff = (pixel_a >= pixel_b) ? (pixel_a - pixel_b) : (pixel_b - pixel_a);
   assign sq   = diff * diff;
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign sq_top = prod_ff[61:30];

   always_comb begin
      if (depth_ff == '0)             depth_eff = 4'd1;
      else if (depth_ff > 4'd8)       depth_eff = 4'd8;
      else                            depth_eff = depth_ff;
      peak = 8'((9'd1 << depth_eff) - 9'd1);
   end

   always_comb begin
      case (cmd.log_sel)
         LOG_SEL_PEAK:  log_src = LOG_W'(peak);
         LOG_SEL_SUM:   log_src = LOG_W'(sum_ff);
         LOG_SEL_COUNT: log_src = LOG_W'(cnt_ff);
         default:       log_src = '0;
      endcase
      case (cmd.log_sel)
         LOG_SEL_PEAK:  term = DSUM_W'({e_ff, frac_ff});
         default:       term = DSUM_W'({e_ff, frac_ff});
      endcase
   end

   always_comb begin
      depth_in = csr_we ? csr_wdata : depth_ff;

      // accumulate; drop pairs beyond the frame capacity
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (cmd.clear) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (cmd.acc_en && (cnt_ff < CNT_W'(MAX_PIXELS))) begin
         sum_in = sum_ff + SUM_W'(sq);
         cnt_in = cnt_ff + 1'b1;
      end

      // restoring divider, one quotient bit per step
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = DIV_W'({sum_ff, 8'b0}) + DIV_W'(cnt_ff >> 1);
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, cnt_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, cnt_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end

      // log unit: normalize, then square and pick one fraction bit per pass
      logx_in = logx_ff;
      e_in    = e_ff;
      y_in    = y_ff;
      prod_in = prod_ff;
      frac_in = frac_ff;
      if (cmd.log_load) begin
         logx_in = log_src;
         e_in    = E_W'(LOG_W - 1);
         frac_in = '0;
      end else if (cmd.norm_step) begin
         logx_in = {logx_ff[LOG_W-2:0], 1'b0};
         e_in    = e_ff - 1'b1;
      end
      if (cmd.log_mant) y_in = logx_ff[LOG_W-1 -: MANT_W];
      if (cmd.sq_mul) prod_in = y_ff * y_ff;
      if (cmd.sq_sel) begin
         frac_in = {frac_ff[14:0], sq_top[31]};
         y_in    = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
      end

      // weighted sum of the three logs
      dsum_in = dsum_ff;
      if (cmd.div_start) dsum_in = '0;
      else if (cmd.dsum_add) begin
         case (cmd.log_sel)
            LOG_SEL_PEAK:  dsum_in = dsum_ff + $signed((term << 4) + (term << 2));
            LOG_SEL_SUM:   dsum_in = dsum_ff - $signed((term << 3) + (term << 1));
            default:       dsum_in = dsum_ff + $signed((term << 3) + (term << 1));
         endcase
      end

      // scale by log10(2), round half away from zero, clamp
      mag      = dsum_ff[DSUM_W-1] ? DSUM_W'(-dsum_ff) : DSUM_W'(dsum_ff);
      neg_in   = cmd.scale_mul ? dsum_ff[DSUM_W-1] : neg_ff;
      sprod_in = cmd.scale_mul ? (63'(mag) * 63'(LOG10_2_Q32)) : sprod_ff;
      rounded  = 64'(sprod_ff) + (64'd1 << 39);
      q        = (rounded[63:40] > 24'd65536) ? 24'd65536 : rounded[63:40];
      psnr_in  = psnr_ff;
      if (cmd.scale_fin) begin
         if (neg_ff) psnr_in = (q > 24'd32768) ? 16'h8000 : 16'(-q);
         else        psnr_in = (q > 24'd32767) ? 16'h7FFF : q[15:0];
      end

      // output register; free again once the held item is taken
      vld_in      = vld_ff && !rsp_tready;
      mse_in      = mse_ff;
      out_psnr_in = out_psnr_ff;
      ident_in    = ident_ff;
      if (cmd.result_load) begin
         vld_in      = 1'b1;
         ident_in    = status.sum_zero;
         mse_in      = status.sum_zero ? 24'd0 : quo_ff[23:0];
         out_psnr_in = status.sum_zero ? PSNR_IDENT : psnr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_W'(8);
         sum_ff   <= '0;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      logx_ff     <= logx_in;
      e_ff        <= e_in;
      y_ff        <= y_in;
      prod_ff     <= prod_in;
      frac_ff     <= frac_in;
      dsum_ff     <= dsum_in;
      neg_ff      <= neg_in;
      sprod_ff    <= sprod_in;
      psnr_ff     <= psnr_in;
      mse_ff      <= mse_in;
      out_psnr_ff <= out_psnr_in;
      ident_ff    <= ident_in;
   end

   assign status.sum_zero = (sum_ff == '0);
   assign status.log_top  = logx_ff[LOG_W-1];
   assign status.rsp_busy = vld_ff && !rsp_tready;

   assign rsp_tvalid    = vld_ff;
   assign rsp_mse       = mse_ff;
   assign rsp_psnr      = out_psnr_ff;
   assign rsp_identical = ident_ff;

endmodule

// ----- rtl/core/image_psnr_meter_unit.sv -----
// Top level of the PSNR / MSE meter for two gray images.
//
//   channel | direction | payload
//   req_    | in        | tdata: pixel_a, pixel_b; tlast: end of frame
//   rsp_    | out       | tdata: mse, psnr; tuser: identical
//   csr_    | in        | wdata: bit_depth (write only)
//
// The block takes one pixel pair per cycle and pairs stream back to back
// outside wrap-up. The pair marked last starts the frame wrap-up: a check
// step, a restoring divider (SUM_W + 9 steps), then three passes of the
// shared log unit (a load, up to LOG_W - 1 normalize shifts plus a mantissa
// latch, a square and a select for each fraction bit, and an accumulate
// each), then a scale multiply, a scale finish and the load of the output
// register. An identical frame goes from the check straight to the output
// register. req_tready is low during wrap-up. Reset is synchronous and restores
// bit_depth 8 with both accumulators empty. A stalled result waits in the
// output register while the next frame streams in.
module image_psnr_meter_unit import ipm_pkg::*; #(
   parameter int MAX_PIXELS = 1048576
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [7:0] pixel_a, [15:8] pixel_b
   input  logic        req_tlast,    // final pixel pair of the frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [23:0] mse, [39:24] psnr
   output logic        rsp_tuser,    // [0] identical
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata     // bit_depth
);

   // Count must hold MAX_PIXELS; the square sum grows by up to 16 bits per pair.
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W = CNT_W + 16;
   // Dividend is square_sum * 256 plus half the count, with carry room.
   localparam int DIV_W = SUM_W + 9;

   cmd_type    cmd;
   status_type status;
   logic [23:0] mse;
   logic [15:0] psnr;

   ipm_controller #(
      .DIV_W (DIV_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ipm_datapath #(
      .MAX_PIXELS (MAX_PIXELS),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W),
      .DIV_W      (DIV_W)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .pixel_a       (req_tdata[7:0]),
      .pixel_b       (req_tdata[15:8]),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_mse       (mse),
      .rsp_psnr      (psnr),
      .rsp_identical (rsp_tuser)
   );

   // Pack the result item, mse in the low bits.
   assign rsp_tdata = {psnr, mse};

endmodule

// ----- rtl/core/ipm_checker.sv -----
// Port-level checks of the PSNR meter, bound to the top level.
`include "image_psnr_meter_unit_assert.svh"

module ipm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_we,
   input logic [3:0]  csr_wdata
);

   // a held result stays offered until taken
   `IPM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // wrap-up of a frame blocks the input side in the cycle after the last pair is taken
   `IPM_ASSERT_NEXT(a_last_blocks, req_tvalid && req_tready && req_tlast, !req_tready)
   // identical frame reports zero error and the fixed PSNR code
   `IPM_ASSERT_NOW(a_ident_code, rsp_tvalid && rsp_tuser,
      rsp_tdata[23:0] == 24'd0 && rsp_tdata[39:24] == 16'hFF00)
   // a result appears only after a frame-ending item
   `IPM_ASSERT_NEXT(a_no_early, !rsp_tvalid && req_tready && !(req_tvalid && req_tlast),
      !rsp_tvalid)

endmodule

bind image_psnr_meter_unit ipm_checker u_chk (.*);

// ----- test/image_psnr_meter_unit_tb.sv -----
// Self-checking testbench for the PSNR / MSE meter: directed frames, then random streams.
`timescale 1ns / 100ps

module image_psnr_meter_unit_tb;
   import ipm_pkg::*;

   localparam int MAX_PIX       = 1048576;
   localparam int ITEM_TARGET   = 850;
   localparam int WATCHDOG_MAX  = 200000;
   localparam int WRAPUP_CYCLES = 400;

   typedef struct packed {
      logic [23:0] mse;
      logic [15:0] psnr;
      logic        identical;
   } frame_score_type;

   typedef struct {
      logic [7:0] pa;
      logic [7:0] pb;
      logic       last;
      logic       check_fixed;
      logic [23:0] mse;
      logic [15:0] psnr;
      logic        identical;
   } pair_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] pixel_a, [15:8] pixel_b
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [23:0] mse, [39:24] psnr
   logic        rsp_tuser;        // [0] identical
   logic        csr_we = 1'b0;
   logic [3:0]  csr_wdata = 4'd0;

   // Predictor state, mirrors the block's accumulators and register.
   logic [3:0]  depth_reg;
   logic [35:0] sq_sum;
   logic [20:0] pix_count;

   frame_score_type score_queue[$];
   frame_score_type fixed_queue[$];   // typed-in expectations, parallel flag per score
   bit              fixed_flag[$];

   int  error_count = 0;
   int  idle_cycles = 0;
   bit  timed_out = 0;
   int  random_items = 0;

   image_psnr_meter_unit #(.MAX_PIXELS(MAX_PIX)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // log2 with 16 fraction bits, truncated bit-by-bit squaring
   function automatic logic [63:0] log2_q16(input logic [63:0] x);
      int          top;
      logic [63:0] y;
      logic [63:0] frac;
      top = 0;
      frac = 0;
      if (x == 0) return 0;
      for (int i = 0; i < 64; i++) if (x[i]) top = i;
      y = (top >= 30) ? (x >> (top - 30)) : (x << (30 - top));
      for (int i = 0; i < 16; i++) begin
         y = (y * y) >> 30;
         frac = frac << 1;
         if (y >= 64'h8000_0000) begin
            frac[0] = 1'b1;
            y = y >> 1;
         end
      end
      return (64'(top) << 16) | frac;
   endfunction

   // Score a finished frame from the accumulated error and count.
   function automatic frame_score_type score_frame(input logic [35:0] ssum,
                                                   input logic [20:0] cnt,
                                                   input logic [3:0]  dep);
      frame_score_type r;
      logic [63:0]     mse_full, peak, mag, q;
      longint          dsum, ps;
      int              d;
      if (ssum == 0) begin
         r.mse = '0;
         r.psnr = PSNR_IDENT;
         r.identical = 1'b1;
         return r;
      end
      mse_full = cnt ? ((64'(ssum) * 256 + 64'(cnt) / 2) / 64'(cnt)) : 64'd0;
      d = (dep < 1) ? 1 : ((dep > 8) ? 8 : int'(dep));
      peak = (64'd1 << d) - 1;
      dsum = 20 * longint'(log2_q16(peak)) - 10 * longint'(log2_q16(64'(ssum)))
           + 10 * longint'(log2_q16(cnt ? 64'(cnt) : 64'd1));
      mag = (dsum < 0) ? 64'(-dsum) : 64'(dsum);
      q = (mag * 64'd1292913986 + (64'd1 << 39)) >> 40;
      if (q > 65536) q = 65536;
      ps = (dsum < 0) ? -longint'(q) : longint'(q);
      if (ps > 32767) ps = 32767;
      if (ps < -32768) ps = -32768;
      r.mse = mse_full[23:0];
      r.psnr = ps[15:0];
      r.identical = 1'b0;
      return r;
   endfunction

   // Advance the predictor by one accepted pair.
   task automatic predict_pair(input logic [7:0] pa, input logic [7:0] pb, input logic last,
                               input bit has_fixed, input frame_score_type fixed_val);
      int diff;
      diff = (pa >= pb) ? pa - pb : pb - pa;
      if (pix_count < MAX_PIX) begin
         sq_sum += 36'(diff * diff);
         pix_count += 1;
      end
      if (last) begin
         score_queue.push_back(score_frame(sq_sum, pix_count, depth_reg));
         fixed_flag.push_back(has_fixed);
         fixed_queue.push_back(fixed_val);
         sq_sum = '0;
         pix_count = '0;
      end
   endtask

   // Send one pair: random gap, hold until accepted. Valid stays high after the
   // accept so a back-to-back pair follows without a second drive of valid in
   // the same step; a gap or a caller that stops sending drops it.
   task automatic send_pair(input logic [7:0] pa, input logic [7:0] pb, input logic last,
                            input bit has_fixed, input frame_score_type fixed_val);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
            ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pb, pa};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_pair(pa, pb, last, has_fixed, fixed_val);
   endtask

   // Wait until every expected result has come, then let any wrap-up finish.
   task automatic drain_scores();
      req_tvalid <= 1'b0;
      while (score_queue.size() != 0 && !timed_out) @(posedge clock);
      repeat (WRAPUP_CYCLES) @(posedge clock);
   endtask

   // Write the depth register while the block is idle.
   task automatic write_depth(input logic [3:0] value);
      req_tvalid <= 1'b0;
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      depth_reg = value;
   endtask

   // Send a frame of random content; err_max bounds the pixel difference, but for an occasional random pixel_b.
   task automatic send_frame(input int len, input int err_max);
      logic [7:0]      pa, pb;
      int              dv;
      frame_score_type none;
      none = '0;
      for (int i = 0; i < len; i++) begin
         pa = 8'($urandom_range(0, 255));
         dv = $urandom_range(0, err_max);
         pb = ($urandom_range(0, 1) && pa >= dv) ? 8'(int'(pa) - dv) :
              ((int'(pa) + dv <= 255) ? 8'(int'(pa) + dv) : 8'(int'(pa) - dv));
         if ($urandom_range(0, 9) == 0) pb = 8'($urandom_range(0, 255));
         send_pair(pa, pb, i == len - 1, 0, none);
         random_items++;
      end
   endtask

   // Receiver: random stalls; compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      frame_score_type got, exp_score, fix_score;
      bit              has_fix;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.mse = rsp_tdata[23:0];
            got.psnr = rsp_tdata[39:24];
            got.identical = rsp_tuser;
            if (score_queue.size() == 0) begin
               $display("%0t: unexpected result mse=%h psnr=%h identical=%b", $time,
                        got.mse, got.psnr, got.identical);
               error_count++;
            end else begin
               exp_score = score_queue.pop_front();
               has_fix = fixed_flag.pop_front();
               fix_score = fixed_queue.pop_front();
               // typed-in values must agree with the predictor too
               if (has_fix && fix_score != exp_score) begin
                  $display("%0t: table row expected %h, predictor %h", $time,
                           fix_score, exp_score);
                  error_count++;
               end
               if (got.mse != exp_score.mse) begin
                  $display("%0t: mse expected %h actual %h", $time, exp_score.mse, got.mse);
                  error_count++;
               end
               if (got.psnr != exp_score.psnr) begin
                  $display("%0t: psnr expected %h actual %h", $time, exp_score.psnr, got.psnr);
                  error_count++;
               end
               if (got.identical != exp_score.identical) begin
                  $display("%0t: identical expected %b actual %b", $time,
                           exp_score.identical, got.identical);
                  error_count++;
               end
            end
         end
         // mostly ready, some short stalls, a few long ones
         if ($urandom_range(0, 49) == 0) rsp_tready <= 1'b0;
         else if (!rsp_tready) rsp_tready <= ($urandom_range(0, 7) == 0);
         else rsp_tready <= ($urandom_range(0, 5) != 0);
      end
   end

   // Watchdog: count cycles in which no item moves on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_MAX) timed_out = 1;
      end
   end

   initial begin
      pair_row_type    table_rows[$];
      frame_score_type fixed_val;
      logic [3:0]      depths[6];
      depths = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd7};
      depth_reg = 4'd8;
      sq_sum = '0;
      pix_count = '0;

      // Directed table: extremes and identical frames; then a long frame with tiny error.
      // identical frames are typed in: mse 0, psnr -1.0 dB, flag set
      table_rows.push_back('{8'd0,   8'd0,   1, 1, 24'd0, 16'hFF00, 1});
      table_rows.push_back('{8'd255, 8'd255, 1, 1, 24'd0, 16'hFF00, 1});
      table_rows.push_back('{8'hAA,  8'hAA,  0, 0, 0, 0, 0});
      table_rows.push_back('{8'h55,  8'h55,  1, 1, 24'd0, 16'hFF00, 1});
      // worst error on one pixel: mse = 255^2 * 256, psnr 0 dB
      table_rows.push_back('{8'd255, 8'd0,   1, 1, 24'd16646400, 16'h0000, 0});
      table_rows.push_back('{8'd0,   8'd255, 1, 1, 24'd16646400, 16'h0000, 0});
      // single step of difference across a few pixels
      table_rows.push_back('{8'd1,   8'd0,   0, 0, 0, 0, 0});
      table_rows.push_back('{8'd7,   8'd7,   0, 0, 0, 0, 0});
      table_rows.push_back('{8'h80,  8'h7F,  1, 0, 0, 0, 0});
      // bit toggles in both fields
      table_rows.push_back('{8'hF0,  8'h0F,  0, 0, 0, 0, 0});
      table_rows.push_back('{8'h0F,  8'hF0,  1, 0, 0, 0, 0});
      table_rows.push_back('{8'h01,  8'h02,  1, 0, 0, 0, 0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         fixed_val.mse = table_rows[i].mse;
         fixed_val.psnr = table_rows[i].psnr;
         fixed_val.identical = table_rows[i].identical;
         send_pair(table_rows[i].pa, table_rows[i].pb, table_rows[i].last,
                   table_rows[i].check_fixed, fixed_val);
      end
      // tiny error: one unit difference in a long frame rounds mse to zero
      fixed_val = '0;
      for (int i = 0; i < 600; i++)
         send_pair(8'd9, (i == 0) ? 8'd10 : 8'd9, i == 599, 0, fixed_val);
      drain_scores();

      // Walk through depth settings, extremes included; random frames in each phase.
      foreach (depths[k]) begin
         write_depth(depths[k]);
         while (random_items < (k + 1) * ITEM_TARGET / 6 && !timed_out) begin
            case ($urandom_range(0, 3))
               0: send_frame($urandom_range(1, 4), 255);
               1: send_frame($urandom_range(1, 40), $urandom_range(0, 3));
               2: send_frame($urandom_range(1, 60), 255);
               default: send_frame($urandom_range(1, 20), 0);
            endcase
         end
         // hold off new pairs until every result is back
         drain_scores();
      end
      write_depth(4'd8);
      send_frame(30, 255);

      drain_scores();
      if (timed_out) begin
         $display("SCOREBOARD MISMATCH");
      end else if (error_count == 0 && score_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Timeout path: stop the run once the watchdog trips.
   initial begin
      wait (timed_out);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
